[rtl/block_transposition_cipher_macros.svh]
// assertion macros for the block transposition cipher
// used by btc_emitter and block_transposition_cipher; expects aclk and aresetn in scope
`ifndef BLOCK_TRANSPOSITION_CIPHER_MACROS_SVH
`define BLOCK_TRANSPOSITION_CIPHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/btc_pkg.sv]
// shared types and constants of the block transposition cipher
// no dependencies; imported by block_transposition_cipher and btc_emitter
package btc_pkg;

    // block geometry
    localparam int BLOCK_MAX = 8;
    localparam int IDX_W     = $clog2(BLOCK_MAX);
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
    localparam int RAM_DEPTH = 2 * BLOCK_MAX;
    localparam int RAM_AW    = IDX_W + 1;

    // letters and character codes
    localparam int          LETTER_W    = 5;
    localparam int          OUT_W       = 7;
    localparam logic [7:0]  CHAR_UP_A   = 8'd65;
    localparam logic [7:0]  CHAR_UP_Z   = 8'd90;
    localparam logic [7:0]  CHAR_LO_A   = 8'd97;
    localparam logic [7:0]  CHAR_LO_Z   = 8'd122;
    localparam logic [OUT_W-1:0] LETTER_BASE = 7'd65;
    localparam int          NUM_LETTERS = 26;

    // key map layout
    localparam int KEY_W       = 24;
    localparam int KEY_ENT_W   = 3;
    localparam int KEY_ENTRIES = 8;

    // padding lfsr
    localparam int                LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
    localparam int                RECIP_W   = 12;
    localparam int                RECIP_26  = (1 << LFSR_W) / NUM_LETTERS;

    // configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 2'd0,
        CFG_KEY_MAP    = 2'd1,
        CFG_DIRECTION  = 2'd2,
        CFG_PAD_SEED   = 2'd3
    } cfg_index_t;

    localparam logic [3:0]        BLOCK_SIZE_RST = 4'd1;
    localparam logic [KEY_W-1:0]  KEY_MAP_RST    = 24'd16434824;
    localparam logic [LFSR_W-1:0] PAD_SEED_RST   = 16'd1;

    // one finished block handed to the emitter
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] size;
        logic             last;
    } job_t;

    typedef enum logic {
        ST_FILL = 1'b0,
        ST_PAD  = 1'b1
    } fill_state_t;

endpackage

[rtl/block_transposition_cipher.sv]
// top level of the block transposition cipher: filter, fill, padding and configuration
// depends on btc_pkg, btc_ram, btc_emitter and block_transposition_cipher_macros.svh

// Takes one character per cycle while s_ready is high and, after the first block, gives
// one letter per cycle while m_ready allows. Letters are written into a two-bank letter
// RAM; a full block is read back permuted through the RAM's single read port at one letter
// per cycle, unless the output stalls, while the next block fills the other bank. One
// finished block can wait in a slot; input is held off while that slot is full and the
// block ahead of it is still being read out, which happens under output backpressure. A
// message end that leaves a partial block holds input off while the pad letters are
// written, since padding shares the RAM's write port.
`include "block_transposition_cipher_macros.svh"

module block_transposition_cipher
    import btc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // character requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_code,
    input  logic                  s_message_end,
    // letter results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_letter,
    output logic                  m_block_end,
    output logic                  m_message_done
);

    logic [3:0]        block_size_reg, block_size_next;
    logic [KEY_W-1:0]  key_map_reg, key_map_next;
    logic              direction_reg, direction_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    fill_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              wbank_reg, wbank_next;

    logic [CNT_W-1:0]  n_eff;
    logic              accept;
    logic              is_upper;
    logic              is_lower;
    logic              is_letter;
    logic [LETTER_W-1:0] char_letter;
    logic [CNT_W-1:0]  fill_after;
    logic              room;

    logic [LFSR_W-1:0]         lfsr_step;
    logic [LFSR_W+RECIP_W-1:0] pad_prod;
    logic [RECIP_W-1:0]        pad_quot;
    logic [LFSR_W:0]           pad_q26;
    logic [LFSR_W:0]           pad_diff;
    logic [LETTER_W:0]         pad_rem;
    logic [LETTER_W-1:0]       pad_letter;

    logic                ram_wr_en;
    logic [RAM_AW-1:0]   ram_wr_addr;
    logic [LETTER_W-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [RAM_AW-1:0]   ram_rd_addr;
    logic [LETTER_W-1:0] ram_rd_data;

    logic job_push;
    job_t job;
    logic job_ready;

    // effective block size: zero acts as one, large values clip
    always_comb begin
        if (block_size_reg == 4'd0) begin
            n_eff = CNT_W'(1);
        end else if (int'(block_size_reg) > BLOCK_MAX) begin
            n_eff = CNT_W'(BLOCK_MAX);
        end else begin
            n_eff = CNT_W'(block_size_reg);
        end
    end

    // letter filter and case folding
    assign is_upper    = (s_char_code >= CHAR_UP_A) && (s_char_code <= CHAR_UP_Z);
    assign is_lower    = (s_char_code >= CHAR_LO_A) && (s_char_code <= CHAR_LO_Z);
    assign is_letter   = is_upper || is_lower;
    assign char_letter = is_upper ? LETTER_W'(s_char_code - CHAR_UP_A)
                                  : LETTER_W'(s_char_code - CHAR_LO_A);

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_FILL) && job_ready;
    assign room       = (int'(fill_reg) < BLOCK_MAX);
    assign fill_after = (is_letter && room) ? fill_reg + 1'b1 : fill_reg;

    // pad letter: lfsr step, then mod 26 by reciprocal with one correction
    assign lfsr_step  = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_MASK : '0);
    assign pad_prod   = lfsr_step * RECIP_W'(RECIP_26);
    assign pad_quot   = pad_prod[LFSR_W+RECIP_W-1:LFSR_W];
    assign pad_q26    = (LFSR_W+1)'({pad_quot, 4'b0}) + (LFSR_W+1)'({pad_quot, 3'b0})
                      + (LFSR_W+1)'({pad_quot, 1'b0});
    assign pad_diff   = (LFSR_W+1)'(lfsr_step) - pad_q26;
    assign pad_rem    = pad_diff[LETTER_W:0];
    assign pad_letter = (int'(pad_rem) >= NUM_LETTERS)
                      ? LETTER_W'(pad_rem - (LETTER_W+1)'(NUM_LETTERS))
                      : pad_rem[LETTER_W-1:0];

    // fill and padding sequencer
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        wbank_next  = wbank_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = {wbank_reg, fill_reg[IDX_W-1:0]};
        ram_wr_data = char_letter;
        job_push    = 1'b0;
        job.bank    = wbank_reg;
        job.size    = n_eff;
        job.last    = 1'b1;

        case (state_reg)
            ST_FILL: begin
                if (accept) begin
                    ram_wr_en = is_letter && room;
                    job.last  = s_message_end;
                    fill_next = fill_after;
                    if (is_letter && fill_after >= n_eff) begin
                        job_push   = 1'b1;
                        fill_next  = '0;
                        wbank_next = ~wbank_reg;
                    end else if (s_message_end && fill_after != '0) begin
                        job.last = 1'b1;
                        if (fill_after >= n_eff) begin
                            job_push   = 1'b1;
                            fill_next  = '0;
                            wbank_next = ~wbank_reg;
                        end else begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = pad_letter;
                if ((fill_reg + 1'b1) >= n_eff) begin
                    job_push   = 1'b1;
                    fill_next  = '0;
                    wbank_next = ~wbank_reg;
                    state_next = ST_FILL;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // configuration writes and lfsr update
    always_comb begin
        block_size_next = block_size_reg;
        key_map_next    = key_map_reg;
        direction_next  = direction_reg;
        lfsr_next       = (state_reg == ST_PAD) ? lfsr_step : lfsr_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BLOCK_SIZE: block_size_next = cfg_wr_data[3:0];
                CFG_KEY_MAP:    key_map_next    = cfg_wr_data[KEY_W-1:0];
                CFG_DIRECTION:  direction_next  = cfg_wr_data[0];
                CFG_PAD_SEED: begin
                    lfsr_next = (cfg_wr_data[LFSR_W-1:0] == '0) ? PAD_SEED_RST
                                                                : cfg_wr_data[LFSR_W-1:0];
                end
                default: begin
                    lfsr_next = lfsr_reg;
                end
            endcase
        end
    end

    // state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            fill_reg       <= '0;
            wbank_reg      <= 1'b0;
            block_size_reg <= BLOCK_SIZE_RST;
            key_map_reg    <= KEY_MAP_RST;
            direction_reg  <= 1'b0;
            lfsr_reg       <= PAD_SEED_RST;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            wbank_reg      <= wbank_next;
            block_size_reg <= block_size_next;
            key_map_reg    <= key_map_next;
            direction_reg  <= direction_next;
            lfsr_reg       <= lfsr_next;
        end
    end

    // two banks of block letters
    btc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (RAM_DEPTH)
    ) u_letter_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // permuted read-out
    btc_emitter u_emitter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_push       (job_push),
        .job            (job),
        .job_ready      (job_ready),
        .key_map        (key_map_reg),
        .direction      (direction_reg),
        .rd_en          (ram_rd_en),
        .rd_addr        (ram_rd_addr),
        .rd_data        (ram_rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_letter       (m_letter),
        .m_block_end    (m_block_end),
        .m_message_done (m_message_done)
    );

    `BTC_ASSERT_NOW(a_lfsr_nonzero, 1'b1, (lfsr_reg != '0), "padding lfsr locked at zero")
    `BTC_ASSERT_NOW(a_pad_in_block, (state_reg == ST_PAD), (fill_reg < n_eff), "padding past block size")
    `BTC_ASSERT_NEXT(a_pad_ends_clean, (state_reg == ST_PAD && state_next == ST_FILL), (fill_reg == '0), "fill count not cleared after padding")

endmodule

[rtl/btc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module btc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage, read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/btc_emitter.sv]
// block emitter: one pending block slot, permuted read-out from the letter ram
// depends on btc_pkg and block_transposition_cipher_macros.svh
`include "block_transposition_cipher_macros.svh"

module btc_emitter
    import btc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // finished blocks from the fill side
    input  logic                   job_push,
    input  job_t                   job,
    output logic                   job_ready,
    // key configuration
    input  logic [KEY_W-1:0]       key_map,
    input  logic                   direction,
    // letter ram read port
    output logic                   rd_en,
    output logic [RAM_AW-1:0]      rd_addr,
    input  logic [LETTER_W-1:0]    rd_data,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_W-1:0]       m_letter,
    output logic                   m_block_end,
    output logic                   m_message_done
);

    logic             pend_valid_reg, pend_valid_next;
    job_t             pend_reg, pend_next;
    logic             act_valid_reg, act_valid_next;
    job_t             act_reg, act_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_block_end_reg, out_block_end_next;
    logic             out_message_done_reg, out_message_done_next;

    logic             issue;
    logic             at_last;
    logic             finishing;
    logic             take;

    // key entry j as a plain number; entries past the key map are the identity
    function automatic int key_entry(input logic [KEY_W-1:0] key, input int j);
        int ent;
        ent = j;
        if (j < KEY_ENTRIES) begin
            ent = int'(key[KEY_ENT_W*j +: KEY_ENT_W]);
        end
        return ent;
    endfunction

    // source slot of the block for output position p
    function automatic logic [IDX_W-1:0] source_slot(
        input logic [KEY_W-1:0] key,
        input logic             dec,
        input logic [IDX_W-1:0] p,
        input logic [CNT_W-1:0] n
    );
        int  src;
        int  k;
        logic ok;
        src = int'(p);
        if (!dec) begin
            // encrypt: the last letter whose key entry names p
            for (int j = 0; j < BLOCK_MAX; j++) begin
                if (j < int'(n) && key_entry(key, j) == int'(p)) begin
                    src = j;
                end
            end
        end else begin
            // decrypt: p takes letter key[p] unless a later entry claims it
            k  = key_entry(key, int'(p));
            ok = (k < int'(n));
            for (int m = 0; m < BLOCK_MAX; m++) begin
                if (m > int'(p) && m < int'(n) && key_entry(key, m) == k) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                src = k;
            end
        end
        return IDX_W'(src);
    endfunction

    // read issue and hand-over of the pending block
    assign issue     = act_valid_reg && (!out_valid_reg || m_ready);
    assign at_last   = ((CNT_W'(pos_reg) + 1'b1) == act_reg.size);
    assign finishing = issue && at_last;
    assign take      = pend_valid_reg && (!act_valid_reg || finishing);
    assign job_ready = !pend_valid_reg || take;

    assign rd_en   = issue;
    assign rd_addr = {act_reg.bank, source_slot(key_map, direction, pos_reg, act_reg.size)};

    // next state of slot, active block and output stage
    always_comb begin
        pend_valid_next       = pend_valid_reg;
        pend_next             = pend_reg;
        act_valid_next        = act_valid_reg;
        act_next              = act_reg;
        pos_next              = pos_reg;
        out_valid_next        = out_valid_reg;
        out_block_end_next    = out_block_end_reg;
        out_message_done_next = out_message_done_reg;

        if (job_push) begin
            pend_valid_next = 1'b1;
            pend_next       = job;
        end else if (take) begin
            pend_valid_next = 1'b0;
        end

        if (take) begin
            act_valid_next = 1'b1;
            act_next       = pend_reg;
            pos_next       = '0;
        end else if (finishing) begin
            act_valid_next = 1'b0;
        end else if (issue) begin
            pos_next = pos_reg + 1'b1;
        end

        if (issue) begin
            out_valid_next        = 1'b1;
            out_block_end_next    = at_last;
            out_message_done_next = at_last && act_reg.last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_reg             <= pend_next;
        act_reg              <= act_next;
        pos_reg              <= pos_next;
        out_block_end_reg    <= out_block_end_next;
        out_message_done_reg <= out_message_done_next;
    end

    // result channel, letter straight from the ram read register
    assign m_valid        = out_valid_reg;
    assign m_letter       = LETTER_BASE + OUT_W'(rd_data);
    assign m_block_end    = out_block_end_reg;
    assign m_message_done = out_message_done_reg;

    `BTC_ASSERT_NOW(a_push_has_room, job_push, job_ready, "block pushed into a full slot")
    `BTC_ASSERT_NOW(a_pos_in_block, act_valid_reg, (CNT_W'(pos_reg) < act_reg.size), "read position past block")
    `BTC_ASSERT_NEXT(a_block_end_follows, finishing, (m_valid && m_block_end), "last read without block end")

endmodule
